@@ hdl/tkls_pkg.sv @@
`default_nettype none
package tkls_pkg;

   localparam int SCORE_W  = 32;
   localparam int ID_W     = 32;
   localparam int BUDGET_W = 6;
   localparam int RANK_W   = 5;
   localparam int COUNT_W  = 6;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 6'd24;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_INSERTED      = 2'd0,
      ST_INSERTED_DROP = 2'd1,
      ST_REJ_PRIORITY  = 2'd2,
      ST_REJ_BUDGET    = 2'd3
   } status_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [ID_W-1:0]    id;
      logic               emissive;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic apply;
      logic flush_step;
   } tkls_cmd_type;

   typedef struct packed {
      logic req_flush;
      logic out_free;
      logic flush_last;
   } tkls_status_type;

endpackage
`default_nettype wire

@@ hdl/top_k_light_selector.sv @@
// Offer: the input beat is captured, all slots are compared in the search step, then
// the apply step compares and shifts the slot row and registers the status beat,
// holding while a result beat is not taken; no new input is accepted before that step.
// Flush: one beat per entry (one for an empty list) per cycle while result beats are
// taken; the next input can be accepted in the cycle that presents the last beat.
// Reset clears the list count and the emissive count and sets the budget to 24.
`default_nettype none
module top_k_light_selector import tkls_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [BUDGET_W-1:0] csr_wdata,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_action,
   input  wire logic [SCORE_W-1:0]  req_cand_score,
   input  wire logic [ID_W-1:0]     req_cand_id,
   input  wire logic                req_cand_emissive,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [1:0]               rsp_status,
   output logic                     rsp_evicted_valid,
   output logic [ID_W-1:0]          rsp_evicted_id,
   output logic [RANK_W-1:0]        rsp_rank,
   output logic [SCORE_W-1:0]       rsp_entry_score,
   output logic [ID_W-1:0]          rsp_entry_id,
   output logic                     rsp_entry_emissive,
   output logic [COUNT_W-1:0]       rsp_list_count,
   output logic                     rsp_last
);

   tkls_cmd_type    cmd;
   tkls_status_type stat;

   tkls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tkls_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_cand_score     (req_cand_score),
      .req_cand_id        (req_cand_id),
      .req_cand_emissive  (req_cand_emissive),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_id     (rsp_evicted_id),
      .rsp_rank           (rsp_rank),
      .rsp_entry_score    (rsp_entry_score),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_entry_emissive (rsp_entry_emissive),
      .rsp_list_count     (rsp_list_count),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
`default_nettype wire

@@ hdl/tkls_ctrl.sv @@
`default_nettype none
module tkls_ctrl import tkls_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire tkls_status_type stat,
   output tkls_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_APPLY  = 4'b0100,
      S_FLUSH  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = stat.req_flush ? S_FLUSH : S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            if (stat.out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush_step = 1'b1;
               if (stat.flush_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while an item was still in progress");

   a_search_then_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.search |=> (state_ff == S_APPLY))
      else $error("search was not followed by the apply step");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule
`default_nettype wire

@@ hdl/tkls_dp.sv @@
`default_nettype none
module tkls_dp import tkls_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [BUDGET_W-1:0] csr_wdata,
   input  wire logic                req_action,
   input  wire logic [SCORE_W-1:0]  req_cand_score,
   input  wire logic [ID_W-1:0]     req_cand_id,
   input  wire logic                req_cand_emissive,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [1:0]               rsp_status,
   output logic                     rsp_evicted_valid,
   output logic [ID_W-1:0]          rsp_evicted_id,
   output logic [RANK_W-1:0]        rsp_rank,
   output logic [SCORE_W-1:0]       rsp_entry_score,
   output logic [ID_W-1:0]          rsp_entry_id,
   output logic                     rsp_entry_emissive,
   output logic [COUNT_W-1:0]       rsp_list_count,
   output logic                     rsp_last,
   input  wire tkls_cmd_type        cmd,
   output tkls_status_type          stat
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int RK_W  = (IDX_W > RANK_W) ? IDX_W : RANK_W;

   logic [BUDGET_W-1:0]   budget_ff, budget_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      ecount_ff, ecount_in;
   logic [IDX_W-1:0]      rank_ff, rank_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   entry_type             cand_ff;
   entry_type             slot_ff [LIST_DEPTH];
   entry_type             slot_in [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] beats_ff, beats_in;
   logic [LIST_DEPTH-1:0] above_ff, above_in;

   kind_type              rsp_kind_ff, rsp_kind_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [ID_W-1:0]       rsp_evid_ff, rsp_evid_in;
   logic [RANK_W-1:0]     rsp_rank_ff, rsp_rank_in;
   entry_type             rsp_entry_ff, rsp_entry_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Search and insert network.
   logic [LIST_DEPTH-1:0] em_valid;
   logic [LIST_DEPTH-1:0] worst_hot;
   logic [LIST_DEPTH-1:0] shift_up;
   logic [LIST_DEPTH-1:0] beats_next, beats_post;
   logic [LIST_DEPTH-1:0] below, below_prev;
   entry_type             next_slot [LIST_DEPTH];
   entry_type             post_slot [LIST_DEPTH];
   entry_type             post_prev [LIST_DEPTH];
   entry_type             slot_apply [LIST_DEPTH];
   logic [ID_W-1:0]       worst_id;
   logic                  beats_worst;
   logic                  budget_zero, hit, budget_rej, rm, full;
   logic                  prio_rej, drop, commit;
   logic [CNT_W-1:0]      cnt_rm, cnt_apply, ecnt_apply;
   logic [CMP_W-1:0]      cnt_apply_ext;
   logic [RK_W-1:0]       rank_ext;
   logic                  flush_empty, flush_last;

   always_comb begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
         em_valid[k] = slot_ff[k].emissive && (CNT_W'(k) < count_ff);
         beats_in[k] = {cand_ff.score, ~cand_ff.id} > {slot_ff[k].score, ~slot_ff[k].id};
      end
      // A slot sits at or beyond the worst emissive entry when no valid
      // emissive entry lies further down the list.
      for (int k = 0; k < LIST_DEPTH; k++) begin
         above_in[k] = 1'b1;
         for (int j = 0; j < LIST_DEPTH; j++) begin
            if (j > k && em_valid[j]) begin
               above_in[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      worst_hot   = '0;
      worst_id    = '0;
      beats_worst = 1'b0;
      worst_hot[0] = above_ff[0];
      for (int k = 1; k < LIST_DEPTH; k++) begin
         worst_hot[k] = above_ff[k] & ~above_ff[k-1];
      end
      for (int k = 0; k < LIST_DEPTH; k++) begin
         if (worst_hot[k]) begin
            worst_id    = worst_id | slot_ff[k].id;
            beats_worst = beats_worst | beats_ff[k];
         end
      end

      budget_zero = (budget_ff == '0);
      hit         = CMP_W'(ecount_ff) >= CMP_W'(budget_ff);
      budget_rej  = cand_ff.emissive && (budget_zero || (hit && !beats_worst));
      rm          = cand_ff.emissive && !budget_zero && hit && beats_worst;
      full        = !rm && (count_ff == CNT_W'(LIST_DEPTH));
      prio_rej    = !budget_rej && full && !beats_ff[LIST_DEPTH-1];
      drop        = !budget_rej && full && beats_ff[LIST_DEPTH-1];
      commit      = !budget_rej && !prio_rej;
      shift_up    = rm ? above_ff : '0;
      cnt_rm      = count_ff - CNT_W'(rm);
      cnt_apply   = cnt_rm - CNT_W'(drop) + CNT_W'(1);
      ecnt_apply  = ecount_ff + CNT_W'(cand_ff.emissive) - CNT_W'(rm)
                    - CNT_W'(drop && slot_ff[LIST_DEPTH-1].emissive);
      cnt_apply_ext = CMP_W'(commit ? cnt_apply : count_ff);

      // The list with the worst emissive entry taken out closes the gap by
      // pulling each later entry one slot forward.
      next_slot[LIST_DEPTH-1]  = slot_ff[LIST_DEPTH-1];
      beats_next[LIST_DEPTH-1] = beats_ff[LIST_DEPTH-1];
      for (int k = 1; k < LIST_DEPTH; k++) begin
         next_slot[k-1]  = slot_ff[k];
         beats_next[k-1] = beats_ff[k];
      end
      for (int k = 0; k < LIST_DEPTH; k++) begin
         post_slot[k]  = shift_up[k] ? next_slot[k] : slot_ff[k];
         beats_post[k] = shift_up[k] ? beats_next[k] : beats_ff[k];
         below[k]      = (CNT_W'(k) < cnt_rm) && !beats_post[k];
      end
      post_prev[0]  = cand_ff;
      below_prev[0] = 1'b1;
      for (int k = 1; k < LIST_DEPTH; k++) begin
         post_prev[k]  = post_slot[k-1];
         below_prev[k] = below[k-1];
      end
      for (int k = 0; k < LIST_DEPTH; k++) begin
         if (below[k]) begin
            slot_apply[k] = post_slot[k];
         end else if (below_prev[k]) begin
            slot_apply[k] = cand_ff;
         end else begin
            slot_apply[k] = post_prev[k];
         end
      end
   end

   assign flush_empty = (count_ff == '0);
   assign flush_last  = flush_empty || ((CNT_W'(rank_ff) + CNT_W'(1)) == count_ff);
   assign rank_ext    = RK_W'(rank_ff);

   always_comb begin
      budget_in     = csr_we ? csr_wdata : budget_ff;
      count_in      = count_ff;
      ecount_in     = ecount_ff;
      rank_in       = rank_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evid_in   = rsp_evid_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.apply) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_STATUS;
         rsp_rank_in   = '0;
         rsp_entry_in  = '0;
         rsp_last_in   = 1'b1;
         rsp_cnt_in    = cnt_apply_ext[COUNT_W-1:0];
         rsp_ev_in     = rm || drop;
         if (rm) begin
            rsp_evid_in = worst_id;
         end else if (drop) begin
            rsp_evid_in = slot_ff[LIST_DEPTH-1].id;
         end else begin
            rsp_evid_in = '0;
         end
         if (budget_rej) begin
            rsp_status_in = ST_REJ_BUDGET;
         end else if (prio_rej) begin
            rsp_status_in = ST_REJ_PRIORITY;
         end else if (drop) begin
            rsp_status_in = ST_INSERTED_DROP;
         end else begin
            rsp_status_in = ST_INSERTED;
         end
         if (commit) begin
            slot_in   = slot_apply;
            count_in  = cnt_apply;
            ecount_in = ecnt_apply;
         end
      end

      if (cmd.flush_step) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_INSERTED;
         rsp_ev_in     = 1'b0;
         rsp_evid_in   = '0;
         rsp_cnt_in    = '0;
         rsp_last_in   = flush_last;
         if (flush_empty) begin
            rsp_kind_in  = KIND_EMPTY;
            rsp_rank_in  = '0;
            rsp_entry_in = '0;
         end else begin
            rsp_kind_in  = KIND_ENTRY;
            rsp_rank_in  = rank_ext[RANK_W-1:0];
            rsp_entry_in = slot_ff[0];
            slot_in      = next_slot;
         end
         if (flush_last) begin
            rank_in   = '0;
            count_in  = '0;
            ecount_in = '0;
         end else begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= BUDGET_RESET;
         count_ff     <= '0;
         ecount_ff    <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         budget_ff    <= budget_in;
         count_ff     <= count_in;
         ecount_ff    <= ecount_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cand_ff.score    <= req_cand_score;
         cand_ff.id       <= req_cand_id;
         cand_ff.emissive <= req_cand_emissive;
      end
      if (cmd.search) begin
         beats_ff <= beats_in;
         above_ff <= above_in;
      end
      slot_ff       <= slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evid_ff   <= rsp_evid_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.req_flush  = req_action;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.flush_last = flush_last;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_evicted_valid  = rsp_ev_ff;
   assign rsp_evicted_id     = rsp_evid_ff;
   assign rsp_rank           = rsp_rank_ff;
   assign rsp_entry_score    = rsp_entry_ff.score;
   assign rsp_entry_id       = rsp_entry_ff.id;
   assign rsp_entry_emissive = rsp_entry_ff.emissive;
   assign rsp_list_count     = rsp_cnt_ff;
   assign rsp_last           = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("list count exceeds the list depth");

   a_ecount_range: assert property (@(posedge clock) disable iff (reset)
      ecount_ff <= count_ff)
      else $error("emissive count exceeds the list count");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply || cmd.flush_step) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over a beat that was not taken");

   a_apply_result: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> (rsp_valid_ff && rsp_last_ff))
      else $error("offer did not produce a final result beat");

endmodule
`default_nettype wire
